// ----- rtl/core/longest_prefix_match_route_table_core_defines.svh -----
// assertion macros shared by the route table rtl
`ifndef LONGEST_PREFIX_MATCH_ROUTE_TABLE_CORE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_ROUTE_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LPMRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route table check failed");

// next-cycle implication, checked outside reset
`define LPMRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route table check failed");

`endif

// ----- rtl/core/lpmrt_pkg.sv -----
// shared types and constants of the route table
`default_nettype none
package lpmrt_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int ENT_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [5:0] MAX_PREFIX = 6'd32;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISS    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UPDATED = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] net;
    logic [5:0]  len;
    logic [7:0]  hop;
  } route_entry_t;

  typedef struct packed {
    logic match;
    logic exact;
  } cmp_t;

endpackage
`default_nettype wire

// ----- rtl/core/lpmrt_cmp.sv -----
// shared compare unit: masked prefix match and exact pair match of one entry
`default_nettype none
module lpmrt_cmp import lpmrt_pkg::*; (
  input  route_entry_t entry,
  input  logic [31:0]  address,
  input  logic [5:0]   prefix_length,
  output cmp_t         result
);

  logic [31:0] mask;
  logic [5:0]  shift;

  always_comb begin
    shift = MAX_PREFIX - entry.len;
    if (entry.len == 6'd0 || entry.len > MAX_PREFIX) begin
      mask = 32'h0;
    end else begin
      mask = 32'hFFFF_FFFF << shift;
    end
    result.match = ((address & mask) == (entry.net & mask));
    result.exact = (address == entry.net) && (prefix_length == entry.len);
  end

endmodule
`default_nettype wire

// ----- rtl/core/longest_prefix_match_route_table_core.sv -----
// ipv4 longest prefix match route table: top level with sequencer and entry memory
//
// Commands come in on the cmd channel (cmd_valid / cmd_stall) as one beat of
// command, address, prefix_length and next_hop; each beat gives exactly one
// response beat of status, hop_found and match_length on the rsp channel
// (rsp_valid / rsp_stall). One command is worked on at a time; cmd_stall is
// high from the accepting edge until the response is written to the output
// register.
// Lookup, add and remove walk the stored routes through one compare unit, one
// entry per cycle off the single read port of the entry memory. Remove then
// moves every route behind the removed one a slot down to close the gap,
// through the same read port. Add or remove with a prefix length above 32,
// and the unused command code, skip the walk and answer with a miss.
// Reset empties the table (entry count to zero) and drops any pending response;
// the entry memory itself is not cleared. When the receiver stalls, the
// response holds in the output register and the next command may still be
// accepted, but it finishes only once that response is taken.
`default_nettype none
`include "longest_prefix_match_route_table_core_defines.svh"
module longest_prefix_match_route_table_core import lpmrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [31:0] address,
  input  logic [5:0]  prefix_length,
  input  logic [7:0]  next_hop,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [7:0]  hop_found,
  output logic [5:0]  match_length
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_ACT   = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state;

  route_entry_t mem [ROUTE_ENTRIES];
  route_entry_t rd_data;
  route_entry_t wr_data;
  logic             rd_en;
  logic             wr_en;
  logic [ENT_W-1:0] rd_addr;
  logic [ENT_W-1:0] wr_addr;

  logic [1:0]       cmd_q;
  logic [31:0]      addr_q;
  logic [5:0]       len_q;
  logic [7:0]       hop_q;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic             pend;
  logic [ENT_W-1:0] pend_idx;

  logic             best_found;
  logic [5:0]       best_len;
  logic [7:0]       best_hop;
  logic             ex_found;
  logic [ENT_W-1:0] ex_idx;

  logic [1:0]       res_status;
  logic [7:0]       res_hop;
  logic [5:0]       res_len;

  cmp_t             cmp;
  logic             accept;
  logic             has_room;

  lpmrt_cmp u_cmp (
    .entry         (rd_data),
    .address       (addr_q),
    .prefix_length (len_q),
    .result        (cmp)
  );

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign has_room  = (count < CNT_W'(ROUTE_ENTRIES));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[ENT_W-1:0];
    wr_en   = 1'b0;
    wr_addr = ex_idx;
    wr_data = '{net: addr_q, len: len_q, hop: hop_q};
    case (state)
      S_SCAN: begin
        rd_en = (idx < count);
      end
      S_ACT: begin
        if (cmd_q == CMD_ADD) begin
          if (ex_found) begin
            wr_en = 1'b1;
          end else if (has_room) begin
            wr_en   = 1'b1;
            wr_addr = count[ENT_W-1:0];
          end
        end
      end
      S_SHIFT: begin
        rd_en = (idx < count);
        // move the entry read last cycle one slot down
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx - ENT_W'(1);
          wr_data = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      pend     <= rd_en;
      pend_idx <= idx[ENT_W-1:0];
      if (rd_en) begin
        idx <= idx + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= command;
            addr_q     <= address;
            len_q      <= prefix_length;
            hop_q      <= next_hop;
            idx        <= '0;
            best_found <= 1'b0;
            best_len   <= '0;
            best_hop   <= '0;
            ex_found   <= 1'b0;
            ex_idx     <= '0;
            res_status <= ST_MISS;
            res_hop    <= '0;
            res_len    <= '0;
            if (command == CMD_LOOKUP ||
                ((command == CMD_ADD || command == CMD_REMOVE) &&
                 prefix_length <= MAX_PREFIX)) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (pend) begin
            if (cmd_q == CMD_LOOKUP) begin
              // strictly longer wins, so the earliest of equal lengths stays
              if (cmp.match && (!best_found || rd_data.len > best_len)) begin
                best_found <= 1'b1;
                best_len   <= rd_data.len;
                best_hop   <= rd_data.hop;
              end
            end else if (cmp.exact && !ex_found) begin
              ex_found <= 1'b1;
              ex_idx   <= pend_idx;
            end
          end
          if (!rd_en && !pend) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          state <= (cmd_q == CMD_REMOVE && ex_found) ? S_SHIFT : S_FIN;
          case (cmd_q)
            CMD_LOOKUP: begin
              if (best_found) begin
                res_status <= ST_DONE;
                res_hop    <= best_hop;
                res_len    <= best_len;
              end
            end
            CMD_ADD: begin
              if (ex_found) begin
                res_status <= ST_UPDATED;
              end else if (has_room) begin
                res_status <= ST_DONE;
                count      <= count + CNT_W'(1);
              end else begin
                res_status <= ST_FULL;
              end
            end
            CMD_REMOVE: begin
              if (ex_found) begin
                res_status <= ST_DONE;
                idx        <= CNT_W'(ex_idx) + CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        S_SHIFT: begin
          if (!rd_en && !pend) begin
            count <= count - CNT_W'(1);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            status       <= res_status;
            hop_found    <= res_hop;
            match_length <= res_len;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LPMRT_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(ROUTE_ENTRIES))
  `LPMRT_ASSERT_NOW(a_write_phase, wr_en, state == S_ACT || state == S_SHIFT)
  `LPMRT_ASSERT_NEXT(a_busy_after_accept, accept, state != S_IDLE)
  `LPMRT_ASSERT_NEXT(a_count_step, 1'b1,
                     count == $past(count) || count == $past(count) + CNT_W'(1) ||
                     count == $past(count) - CNT_W'(1))

endmodule
`default_nettype wire
